// File: rtl/rapid_trigger_key_judge_macros.svh
// -----------------------------------------------------------------------------
// Rapid trigger key judge: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// -----------------------------------------------------------------------------
`ifndef RAPID_TRIGGER_KEY_JUDGE_MACROS_SVH
`define RAPID_TRIGGER_KEY_JUDGE_MACROS_SVH

// Same-cycle implication.
`define RTKJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rapid trigger key judge: check failed");

// Next-cycle implication.
`define RTKJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rapid trigger key judge: check failed");

`endif

// File: rtl/rtkj_pkg.sv
// -----------------------------------------------------------------------------
// Rapid trigger key judge package
// Constants, key modes, event codes, register indexes and the word types of
// the sample and result channels.
// -----------------------------------------------------------------------------
package rtkj_pkg;

	localparam int NUM_KEYS          = 64;
	localparam int LIFT_OFF_DISTANCE = 1000;
	localparam int KEY_IDX_W         = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int POS_W             = 16;
	localparam int CFG_IDX_W         = 3;
	localparam logic [POS_W-1:0] FULL_STROKE_RESET = 16'd4000;

	// Per-key mode.
	typedef enum logic [2:0] {
		MODE_RELEASED  = 3'd0,
		MODE_PRESSED   = 3'd1,
		MODE_CANCELING = 3'd2,
		MODE_CANCELED  = 3'd3,
		MODE_REMOVED   = 3'd4
	} mode_t;

	// Reported event.
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} event_t;

	// Item function.
	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_CANCEL = 1'b1
	} func_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTUATE_POINT     = 3'd0,
		REG_ACTUATE_TRIGGER   = 3'd1,
		REG_RESET_POINT       = 3'd2,
		REG_RESET_TRIGGER     = 3'd3,
		REG_FULL_STROKE       = 3'd4,
		REG_ACTUATE_HEIGHT    = 3'd5,
		REG_ACTUATE_POINT_LOW = 3'd6,
		REG_RESET_POINT_TOP   = 3'd7
	} reg_idx_t;

	// Sample channel word.
	typedef struct packed {
		logic             func;
		logic [7:0]       key_index;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] calib_offset;
		logic [POS_W-1:0] cancel_threshold;
	} sample_t;

	// Result channel word.
	typedef struct packed {
		logic [7:0] out_key;
		logic [1:0] key_event;
		logic [2:0] key_status;
	} result_t;

	// One key's stored state.
	typedef struct packed {
		mode_t            mode;
		logic [POS_W-1:0] ref_pos;
		logic [POS_W-1:0] cur_pos;
	} key_entry_t;

endpackage

// File: rtl/rapid_trigger_key_judge.sv
// -----------------------------------------------------------------------------
// Rapid trigger key judge
// Per-key dynamic actuation for analog keys. Key state lives in one
// synchronous memory that is read on accept and written back one stage later.
// -----------------------------------------------------------------------------
//
//   channel  | valid         | stall         | word
//   ---------+---------------+---------------+--------------
//   sample   | sample_valid  | sample_stall  | sample_word
//   result   | result_valid  | result_stall  | result_word
//   config   | cfg_we        | (none)        | cfg_index, cfg_data
//
// One word is accepted per cycle while sample_stall is low. It passes a memory
// read stage and a judge stage that writes back, then the output register.
// A word for the key that the judge stage is writing at the same edge takes
// the written entry through a forwarding register.
// Reset clears every key to released through a valid bit per key; no
// clearing pass is needed.
// A stalled result holds in the output register; the judge stage then holds,
// and sample_stall rises only while both are full.
// -----------------------------------------------------------------------------
module rapid_trigger_key_judge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  rtkj_pkg::sample_t                   sample_word,
	output logic                                result_valid,
	input  logic                                result_stall,
	output rtkj_pkg::result_t                   result_word,
	input  logic                                cfg_we,
	input  logic [rtkj_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtkj_pkg::POS_W-1:0]          cfg_data
);

	localparam int PW = rtkj_pkg::POS_W;
	localparam int KW = rtkj_pkg::KEY_IDX_W;
	localparam int NK = rtkj_pkg::NUM_KEYS;

	// Configuration registers.
	logic [PW-1:0] actuate_point_q, actuate_trigger_q, reset_point_q, reset_trigger_q;
	logic [PW-1:0] full_stroke_q, actuate_height_q, actuate_point_low_q, reset_point_top_q;

	// Key state memory and valid bits.
	rtkj_pkg::key_entry_t key_mem [NK];
	logic [NK-1:0]        key_vld_q;

	// Handshake.
	logic s1_valid_q, out_valid_q, out_free, s1_adv, accept;

	// Judge stage registers.
	rtkj_pkg::sample_t    item_s1;
	logic                 in_range_s1;
	logic [KW-1:0]        idx_s1;
	rtkj_pkg::key_entry_t rd_entry_s1;
	logic                 rd_vld_s1;
	logic                 fwd_s1;
	logic [PW-1:0]        top_h_s1, low_pt_s1;
	logic [PW-1:0]        th_rel_top_s1, th_rel_low_s1, th_rel_mid_s1;
	logic [PW-1:0]        th_prs_top_s1, th_prs_mid_s1;

	// Last written entry, for forwarding.
	rtkj_pkg::key_entry_t wr_entry_q;

	// Judge results.
	rtkj_pkg::key_entry_t cur_entry, new_entry;
	rtkj_pkg::event_t     new_event;
	logic                 new_in_range;
	logic [KW-1:0]        new_idx;
	logic [PW:0]          lift_limit;
	logic [PW-1:0]        th;
	logic [PW-1:0]        drop, rise;
	logic                 zone_top, zone_low;

	rtkj_pkg::result_t result_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			actuate_point_q     <= '0;
			actuate_trigger_q   <= '0;
			reset_point_q       <= '0;
			reset_trigger_q     <= '0;
			full_stroke_q       <= rtkj_pkg::FULL_STROKE_RESET;
			actuate_height_q    <= '0;
			actuate_point_low_q <= '0;
			reset_point_top_q   <= '0;
		end else if (cfg_we) begin
			unique case (rtkj_pkg::reg_idx_t'(cfg_index))
				rtkj_pkg::REG_ACTUATE_POINT:     actuate_point_q     <= cfg_data;
				rtkj_pkg::REG_ACTUATE_TRIGGER:   actuate_trigger_q   <= cfg_data;
				rtkj_pkg::REG_RESET_POINT:       reset_point_q       <= cfg_data;
				rtkj_pkg::REG_RESET_TRIGGER:     reset_trigger_q     <= cfg_data;
				rtkj_pkg::REG_FULL_STROKE:       full_stroke_q       <= cfg_data;
				rtkj_pkg::REG_ACTUATE_HEIGHT:    actuate_height_q    <= cfg_data;
				rtkj_pkg::REG_ACTUATE_POINT_LOW: actuate_point_low_q <= cfg_data;
				rtkj_pkg::REG_RESET_POINT_TOP:   reset_point_top_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: the judge stage moves on when the output register is free.
	assign out_free     = !out_valid_q || !result_stall;
	assign s1_adv       = s1_valid_q && out_free;
	assign sample_stall = s1_valid_q && !out_free;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Index of the incoming word.
	assign new_in_range = (sample_word.key_index < 8'(NK));
	assign new_idx      = sample_word.key_index[KW-1:0];

	// Accept stage: issue the memory read and work out the offset-adjusted points.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1       <= sample_word;
			in_range_s1   <= new_in_range;
			idx_s1        <= new_idx;
			fwd_s1        <= s1_adv && in_range_s1 && new_in_range && (idx_s1 == new_idx);
			top_h_s1      <= actuate_height_q - sample_word.calib_offset;
			low_pt_s1     <= reset_point_q + sample_word.calib_offset;
			th_rel_top_s1 <= actuate_point_q + sample_word.calib_offset;
			th_rel_low_s1 <= actuate_point_low_q + sample_word.calib_offset;
			th_rel_mid_s1 <= actuate_trigger_q + sample_word.calib_offset;
			th_prs_top_s1 <= reset_point_top_q + sample_word.calib_offset;
			th_prs_mid_s1 <= reset_trigger_q + sample_word.calib_offset;
			if (new_in_range) begin
				rd_entry_s1 <= key_mem[new_idx];
				rd_vld_s1   <= key_vld_q[new_idx];
			end else begin
				rd_vld_s1   <= 1'b0;
			end
		end
	end

	// Current key entry: forwarded write, stored entry, or the reset value.
	always_comb begin
		if (fwd_s1) begin
			cur_entry = wr_entry_q;
		end else if (rd_vld_s1) begin
			cur_entry = rd_entry_s1;
		end else begin
			cur_entry.mode    = rtkj_pkg::MODE_RELEASED;
			cur_entry.ref_pos = '0;
			cur_entry.cur_pos = '0;
		end
	end

	// Zone and threshold for the sampled position.
	assign zone_top   = (item_s1.position > top_h_s1);
	assign zone_low   = !zone_top && (item_s1.position < low_pt_s1);
	assign lift_limit = {1'b0, full_stroke_q} + (PW+1)'(rtkj_pkg::LIFT_OFF_DISTANCE);
	assign drop       = cur_entry.ref_pos - item_s1.position;
	assign rise       = item_s1.position - cur_entry.ref_pos;

	always_comb begin
		if (cur_entry.mode == rtkj_pkg::MODE_RELEASED) begin
			th = zone_top ? th_rel_top_s1 : (zone_low ? th_rel_low_s1 : th_rel_mid_s1);
		end else begin
			th = zone_top ? th_prs_top_s1 : (zone_low ? low_pt_s1 : th_prs_mid_s1);
		end
	end

	// Judge: next key entry and event.
	always_comb begin
		new_entry = cur_entry;
		new_event = rtkj_pkg::EV_NONE;
		if (item_s1.func == rtkj_pkg::FUNC_CANCEL) begin
			// A pressed key moves to canceling past the threshold, or always at zero.
			if (cur_entry.mode == rtkj_pkg::MODE_PRESSED &&
			    (item_s1.cancel_threshold == '0 ||
			     cur_entry.cur_pos > item_s1.cancel_threshold)) begin
				new_entry.mode = rtkj_pkg::MODE_CANCELING;
			end
		end else begin
			new_entry.cur_pos = item_s1.position;
			case (cur_entry.mode)
				rtkj_pkg::MODE_CANCELING: begin
					new_entry.mode = rtkj_pkg::MODE_CANCELED;
					new_event      = rtkj_pkg::EV_RELEASE;
				end
				rtkj_pkg::MODE_RELEASED: begin
					if ({1'b0, item_s1.position} > lift_limit) begin
						new_entry.mode    = rtkj_pkg::MODE_REMOVED;
						new_entry.ref_pos = full_stroke_q;
					end else if (item_s1.position > cur_entry.ref_pos) begin
						new_entry.ref_pos = item_s1.position;
					end else if (drop > th) begin
						new_entry.ref_pos = item_s1.position;
						new_entry.mode    = rtkj_pkg::MODE_PRESSED;
						new_event         = rtkj_pkg::EV_PRESS;
					end
				end
				rtkj_pkg::MODE_PRESSED, rtkj_pkg::MODE_CANCELED: begin
					if (item_s1.position < cur_entry.ref_pos) begin
						new_entry.ref_pos = item_s1.position;
					end else if (rise > th) begin
						new_entry.ref_pos = item_s1.position;
						new_entry.mode    = rtkj_pkg::MODE_RELEASED;
						if (cur_entry.mode == rtkj_pkg::MODE_PRESSED) begin
							new_event = rtkj_pkg::EV_RELEASE;
						end
					end
				end
				rtkj_pkg::MODE_REMOVED: begin
					if (item_s1.position < full_stroke_q) begin
						new_entry.mode = rtkj_pkg::MODE_RELEASED;
					end
				end
				default: ;
			endcase
		end
	end

	// Write back the judged entry.
	always_ff @(posedge clk) begin
		if (s1_adv && in_range_s1) begin
			key_mem[idx_s1] <= new_entry;
		end
		if (s1_adv) begin
			wr_entry_q <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_q <= '0;
		end else if (s1_adv && in_range_s1) begin
			key_vld_q[idx_s1] <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q.out_key <= item_s1.key_index;
			if (in_range_s1) begin
				result_q.key_event  <= new_event;
				result_q.key_status <= new_entry.mode;
			end else begin
				result_q.key_event  <= rtkj_pkg::EV_NONE;
				result_q.key_status <= rtkj_pkg::MODE_RELEASED;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = result_q;

endmodule

// File: rtl/rtkj_checker.sv
// -----------------------------------------------------------------------------
// Rapid trigger key judge checker
// Port-level checks on the result channel, attached to the top level by bind.
// -----------------------------------------------------------------------------
`include "rapid_trigger_key_judge_macros.svh"

module rtkj_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              result_valid,
	input  logic              result_stall,
	input  rtkj_pkg::result_t result_word
);

	// A stalled result word stays offered.
	`RTKJ_ASSERT_NEXT(a_valid_hold, clk, arst_n, result_valid && result_stall, result_valid)

	// A stalled result word does not change.
	`RTKJ_ASSERT_NEXT(a_word_hold, clk, arst_n, result_valid && result_stall, $stable(result_word))

	// A press always leaves the key pressed.
	`RTKJ_ASSERT_NOW(a_press_status, clk, arst_n, result_valid && result_word.key_event == 2'(rtkj_pkg::EV_PRESS), result_word.key_status == 3'(rtkj_pkg::MODE_PRESSED))

	// A release leaves the key released or canceled.
	`RTKJ_ASSERT_NOW(a_release_status, clk, arst_n, result_valid && result_word.key_event == 2'(rtkj_pkg::EV_RELEASE), result_word.key_status == 3'(rtkj_pkg::MODE_RELEASED) || result_word.key_status == 3'(rtkj_pkg::MODE_CANCELED))

	// A key beyond the key count reports nothing.
	`RTKJ_ASSERT_NOW(a_out_of_range, clk, arst_n, result_valid && result_word.out_key >= 8'(rtkj_pkg::NUM_KEYS), result_word.key_event == 2'(rtkj_pkg::EV_NONE) && result_word.key_status == 3'(rtkj_pkg::MODE_RELEASED))

endmodule

bind rapid_trigger_key_judge rtkj_checker u_rtkj_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);

// File: tb/sv/key_judge_checker.sv
// -----------------------------------------------------------------------------
// Rapid trigger key judge: result checker
// Watches the sample, result and configuration ports of the key judge. It keeps
// its own copy of the registers and of every key's mode and positions, works out
// the result word of each accepted sample word, and compares each accepted
// result word field by field with the oldest one still owed.
// -----------------------------------------------------------------------------
module key_judge_checker
	import rtkj_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  sample_t              sample_word,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  result_t              result_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   results_owed
);

	// Shadow registers and per-key state.
	logic [POS_W-1:0] cfg_shadow [8];
	mode_t            key_mode_q [NUM_KEYS];
	logic [POS_W-1:0] key_ref_q  [NUM_KEYS];
	logic [POS_W-1:0] key_last_q [NUM_KEYS];

	// Result words owed by the block, oldest first.
	result_t owed_results [$];
	result_t want;

	// Points and heights shifted by the calibration offset wrap at 16 bits.
	function automatic int wrap16(int v);
		return v & 'hFFFF;
	endfunction

	// Judges one position sample of key k and updates that key's state.
	function automatic event_t judge_sample(int k, logic [POS_W-1:0] pos,
	                                        logic [POS_W-1:0] off);
		mode_t m;
		int    cur;
		int    base;
		int    delta;
		int    th;
		int    ofs;
		int    stroke;
		int    top_h;
		int    low_pt;
		bit    in_top;
		bit    in_low;
		m      = key_mode_q[k];
		cur    = int'(pos);
		base   = int'(key_ref_q[k]);
		ofs    = int'(off);
		stroke = int'(cfg_shadow[REG_FULL_STROKE]);
		top_h  = wrap16(int'(cfg_shadow[REG_ACTUATE_HEIGHT]) - ofs);
		low_pt = wrap16(int'(cfg_shadow[REG_RESET_POINT]) + ofs);
		key_last_q[k] = pos;

		// A canceling key releases on its next sample, whatever the position.
		if (m == MODE_CANCELING) begin
			key_mode_q[k] = MODE_CANCELED;
			return EV_RELEASE;
		end

		delta  = cur - base;
		in_top = cur > top_h;
		in_low = cur < low_pt;

		// Travel threshold by mode and zone.
		if (m == MODE_RELEASED) begin
			th = in_top ? wrap16(int'(cfg_shadow[REG_ACTUATE_POINT]) + ofs)
			   : in_low ? wrap16(int'(cfg_shadow[REG_ACTUATE_POINT_LOW]) + ofs)
			   : wrap16(int'(cfg_shadow[REG_ACTUATE_TRIGGER]) + ofs);
		end else begin
			th = in_top ? wrap16(int'(cfg_shadow[REG_RESET_POINT_TOP]) + ofs)
			   : in_low ? low_pt
			   : wrap16(int'(cfg_shadow[REG_RESET_TRIGGER]) + ofs);
		end

		case (m)
			MODE_RELEASED: begin
				if (cur > stroke + LIFT_OFF_DISTANCE) begin
					key_mode_q[k] = MODE_REMOVED;
					key_ref_q[k]  = POS_W'(stroke);
				end else if (delta > 0) begin
					key_ref_q[k] = pos;
				end else if (-delta > th) begin
					key_ref_q[k]  = pos;
					key_mode_q[k] = MODE_PRESSED;
					return EV_PRESS;
				end
			end
			MODE_PRESSED, MODE_CANCELED: begin
				// The reference follows the key down; enough travel up releases it.
				if (delta < 0) begin
					key_ref_q[k] = pos;
				end else if (delta > th) begin
					key_ref_q[k]  = pos;
					key_mode_q[k] = MODE_RELEASED;
					if (m == MODE_PRESSED)
						return EV_RELEASE;
				end
			end
			MODE_REMOVED: begin
				if (cur < stroke)
					key_mode_q[k] = MODE_RELEASED;
			end
			default: begin
			end
		endcase
		return EV_NONE;
	endfunction

	// Result word of one sample word; keys out of range change nothing.
	function automatic result_t judge_word(sample_t w);
		result_t r;
		int      k;
		k            = int'(w.key_index);
		r.out_key    = w.key_index;
		r.key_event  = EV_NONE;
		r.key_status = MODE_RELEASED;
		if (k < NUM_KEYS) begin
			if (w.func == FUNC_SAMPLE) begin
				r.key_event = judge_sample(k, w.position, w.calib_offset);
			end else if (key_mode_q[k] == MODE_PRESSED &&
			             (w.cancel_threshold == '0 ||
			              key_last_q[k] > w.cancel_threshold)) begin
				key_mode_q[k] = MODE_CANCELING;
			end
			r.key_status = key_mode_q[k];
		end
		return r;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// Compare accepted results, follow register writes, predict accepted words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (cfg_shadow[i])
				cfg_shadow[i] = '0;
			cfg_shadow[REG_FULL_STROKE] = FULL_STROKE_RESET;
			foreach (key_mode_q[i]) begin
				key_mode_q[i] = MODE_RELEASED;
				key_ref_q[i]  = '0;
				key_last_q[i] = '0;
			end
			owed_results.delete();
			mismatch_count = 0;
			results_owed  <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (owed_results.size() == 0) begin
					flag_mismatch($sformatf("result word for key %0d with none owed",
					                        result_word.out_key));
				end else begin
					want = owed_results.pop_front();
					if (result_word.out_key !== want.out_key)
						flag_mismatch($sformatf("out_key %0d, expected %0d",
						                        result_word.out_key, want.out_key));
					if (result_word.key_event !== want.key_event)
						flag_mismatch($sformatf("key %0d: key_event %0d, expected %0d",
						                        want.out_key, result_word.key_event,
						                        want.key_event));
					if (result_word.key_status !== want.key_status)
						flag_mismatch($sformatf("key %0d: key_status %0d, expected %0d",
						                        want.out_key, result_word.key_status,
						                        want.key_status));
				end
			end
			if (cfg_we)
				cfg_shadow[cfg_index] = cfg_data;
			if (sample_valid && !sample_stall)
				owed_results.push_back(judge_word(sample_word));
			results_owed <= owed_results.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// -----------------------------------------------------------------------------
// Rapid trigger key judge: testbench top
// Drives the key judge with a directed run over presses, releases, cancels,
// removed switches and ignored keys, then with random key movement under
// several register settings, the extremes among them. Both channels idle at
// random; a checker beside the block predicts and compares every result word.
// -----------------------------------------------------------------------------
module tb_top;

	import rtkj_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 106;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample_word  = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_word;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [POS_W-1:0]     cfg_data     = '0;
	int                   mismatch_count;
	int                   results_owed;

	// Stimulus state: register values, key positions and pacing.
	logic [POS_W-1:0] setting [8];
	int               key_pos [NUM_KEYS];
	int               phase_offset;
	int               step_max;
	bit               calm;
	int               rx_hold_left = 0;
	int               rx_draw;

	rapid_trigger_key_judge u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_word  (sample_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	key_judge_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_word    (sample_word),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_word    (result_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Result side: after each accepted word, draw whether and how long to stall
	// the next one; a calm stretch never stalls.
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			rx_draw = calm ? 0 : int'($urandom_range(0, 6));
			rx_hold_left <= rx_draw;
			result_stall <= (rx_draw != 0);
		end else if (result_valid && result_stall) begin
			if (rx_hold_left <= 1)
				result_stall <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// Run ends here if the block stops answering.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic sample_t make_word(func_t f, int k, int pos, int off, int cth);
		sample_t w;
		w.func             = f;
		w.key_index        = 8'(k);
		w.position         = POS_W'(pos);
		w.calib_offset     = POS_W'(off);
		w.cancel_threshold = POS_W'(cth);
		return w;
	endfunction

	function automatic int clamp16(int v);
		return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
	endfunction

	// Random word: mostly key movement on a few busy keys, some cancels,
	// some noise and keys out of range.
	function automatic sample_t random_word();
		sample_t w;
		int      r;
		int      k;
		int      p;
		int      stroke;
		r      = int'($urandom_range(0, 99));
		stroke = int'(setting[REG_FULL_STROKE]);
		w.func             = FUNC_SAMPLE;
		w.position         = POS_W'($urandom_range(0, 65535));
		w.cancel_threshold = POS_W'($urandom_range(0, 65535));
		if (r < 8) begin
			w.func         = func_t'($urandom_range(0, 1));
			w.key_index    = 8'($urandom_range(0, 255));
			w.calib_offset = POS_W'($urandom_range(0, 65535));
			return w;
		end
		p = int'($urandom_range(0, 99));
		k = (p < 75) ? int'($urandom_range(0, 3))
		  : (p < 95) ? int'($urandom_range(0, NUM_KEYS - 1))
		  : int'($urandom_range(NUM_KEYS, 255));
		w.key_index = 8'(k);
		p = int'($urandom_range(0, 99));
		w.calib_offset = (p < 75) ? POS_W'(phase_offset)
		               : (p < 90) ? POS_W'($urandom_range(0, 300))
		               : POS_W'($urandom_range(0, 65535));
		if (k >= NUM_KEYS)
			return w;
		if (r < 20) begin
			// Cancel with no threshold, one near the key's position, or any.
			w.func = FUNC_CANCEL;
			p = int'($urandom_range(0, 2));
			if (p == 0)
				w.cancel_threshold = '0;
			else if (p == 1)
				w.cancel_threshold = POS_W'(clamp16(key_pos[k] +
				                                    int'($urandom_range(0, 400)) - 200));
			return w;
		end
		// Move the key; now and then lift the switch out, and bring a lifted
		// key back down.
		if ($urandom_range(0, 99) < 3)
			p = stroke + LIFT_OFF_DISTANCE + 1 + int'($urandom_range(0, 3000));
		else if (key_pos[k] > stroke)
			p = key_pos[k] - int'($urandom_range(0, step_max + 500));
		else if ($urandom_range(0, 1) == 0)
			p = key_pos[k] + int'($urandom_range(0, step_max));
		else
			p = key_pos[k] - int'($urandom_range(0, step_max));
		p = clamp16(p);
		key_pos[k] = p;
		w.position = POS_W'(p);
		return w;
	endfunction

	// Presents one word after a drawn gap and returns at the edge that takes it.
	task automatic send_word(input sample_t w);
		int gap;
		gap = calm ? 0 : int'($urandom_range(0, 6));
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes every register from the setting table, one per cycle.
	task automatic apply_settings();
		for (int i = 0; i < $size(setting); i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= setting[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic set_typical();
		setting[REG_ACTUATE_POINT]     = 16'd300;
		setting[REG_ACTUATE_TRIGGER]   = 16'd100;
		setting[REG_RESET_POINT]       = 16'd800;
		setting[REG_RESET_TRIGGER]     = 16'd100;
		setting[REG_FULL_STROKE]       = 16'd4000;
		setting[REG_ACTUATE_HEIGHT]    = 16'd3000;
		setting[REG_ACTUATE_POINT_LOW] = 16'd50;
		setting[REG_RESET_POINT_TOP]   = 16'd200;
	endtask

	initial begin
		calm         = 1'b0;
		phase_offset = 0;
		step_max     = 400;
		foreach (key_pos[i])
			key_pos[i] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run under a typical setting.
		set_typical();
		apply_settings();
		send_word(make_word(FUNC_SAMPLE, 0, 3500, 0, 0));     // follow up, top zone
		send_word(make_word(FUNC_SAMPLE, 0, 3100, 0, 0));     // press in top zone
		send_word(make_word(FUNC_SAMPLE, 0, 3000, 0, 0));     // follow down
		send_word(make_word(FUNC_SAMPLE, 0, 3250, 0, 0));     // release in top zone
		send_word(make_word(FUNC_SAMPLE, 0, 2000, 0, 0));     // press in middle zone
		send_word(make_word(FUNC_CANCEL, 0, 0, 0, 0));        // cancel, no threshold
		send_word(make_word(FUNC_SAMPLE, 0, 1900, 0, 0));     // canceling gives release
		send_word(make_word(FUNC_SAMPLE, 0, 2100, 0, 0));     // canceled, rise at threshold, no release
		send_word(make_word(FUNC_SAMPLE, 0, 500, 0, 0));      // canceled follows down into lower zone
		send_word(make_word(FUNC_SAMPLE, 0, 700, 0, 0));      // small rise, stays canceled
		send_word(make_word(FUNC_CANCEL, 0, 0, 0, 65535));    // position under threshold
		send_word(make_word(FUNC_CANCEL, 0, 0, 0, 600));      // position over threshold
		send_word(make_word(FUNC_CANCEL, 1, 0, 0, 0));        // released target untouched
		send_word(make_word(FUNC_SAMPLE, 0, 65535, 0, 0));    // canceled, silent release
		send_word(make_word(FUNC_SAMPLE, 0, 0, 0, 0));        // press in lower zone
		send_word(make_word(FUNC_SAMPLE, 5, 5000, 0, 0));     // exactly at lift-off bound
		send_word(make_word(FUNC_SAMPLE, 2, 5001, 0, 0));     // switch removed
		send_word(make_word(FUNC_SAMPLE, 2, 4500, 0, 0));     // still removed
		send_word(make_word(FUNC_SAMPLE, 2, 3999, 0, 0));     // back to released
		send_word(make_word(FUNC_SAMPLE, 63, 65535, 65535, 65535));
		send_word(make_word(FUNC_SAMPLE, 3, 100, 65535, 0));  // offset wraps
		send_word(make_word(FUNC_SAMPLE, 3, 65535, 1, 0));
		send_word(make_word(FUNC_SAMPLE, NUM_KEYS, 1234, 0, 0));
		send_word(make_word(FUNC_CANCEL, 255, 65535, 65535, 65535));
		drain();

		// Random runs, one register setting per phase.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					foreach (setting[i])
						setting[i] = '0;
					phase_offset = 0;
					step_max     = 300;
				end
				1: begin
					foreach (setting[i])
						setting[i] = 16'hFFFF;
					phase_offset = int'($urandom_range(0, 65535));
					step_max     = 20000;
				end
				2: begin
					set_typical();
					phase_offset = int'($urandom_range(0, 100));
					step_max     = 800;
				end
				default: begin
					setting[REG_FULL_STROKE] = ($urandom_range(0, 9) == 0)
					                         ? POS_W'($urandom_range(0, 65535))
					                         : POS_W'($urandom_range(500, 6000));
					step_max = int'($urandom_range(20, 1500));
					foreach (setting[i])
						if (i != REG_FULL_STROKE)
							setting[i] = ($urandom_range(0, 3) == 0)
							           ? POS_W'($urandom_range(0, 65535))
							           : POS_W'($urandom_range(0, setting[REG_FULL_STROKE]));
					phase_offset = ($urandom_range(0, 3) == 0)
					             ? int'($urandom_range(0, 65535))
					             : int'($urandom_range(0, 200));
				end
			endcase
			apply_settings();
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 99) == 0)
					drain();
				send_word(random_word());
			end
			drain();
		end

		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
